// File: rtl/ubds_pkg.sv
package ubds_pkg;

  localparam int unsigned CLOCK_W     = 27;
  localparam int unsigned BAUD_W      = 24;
  localparam int unsigned OSR_FIELD_W = 6;
  localparam int unsigned DIV_FIELD_W = 13;
  localparam int unsigned RATE_W      = 27;

  localparam logic [CLOCK_W-1:0] CLOCK_RESET = CLOCK_W'(24000000);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_M,
    S_DIV_M,
    S_MUL_A,
    S_DIV_A,
    S_ERR,
    S_BEST,
    S_NEXT
  } ubds_state_e;

endpackage

// File: rtl/ubds_req_if.sv
interface ubds_req_if
  import ubds_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [BAUD_W-1:0] target_baud;

  modport source (output valid, output target_baud, input ready);
  modport sink (input valid, input target_baud, output ready);

endinterface

// File: rtl/ubds_rsp_if.sv
interface ubds_rsp_if
  import ubds_pkg::*;
();

  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [OSR_FIELD_W-1:0] best_osr;
  logic [DIV_FIELD_W-1:0] best_divisor;
  logic [RATE_W-1:0]      achieved_baud;
  logic [RATE_W-1:0]      error_hz;

  modport source (
    output valid, output found, output best_osr, output best_divisor,
    output achieved_baud, output error_hz, input ready
  );
  modport sink (
    input valid, input found, input best_osr, input best_divisor,
    input achieved_baud, input error_hz, output ready
  );

endinterface

// File: rtl/ubds_divider.sv
// Restoring divider, one quotient bit per cycle.
module ubds_divider #(
  parameter int unsigned N = 27,
  parameter int unsigned D = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [D-1:0] divisor_i,
  output logic         done_o,
  output logic [N-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(N + 1);

  logic [D-1:0]     rem_q, rem_d;
  logic [N-1:0]     quo_q, quo_d;
  logic [D-1:0]     dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [D:0]       rem_shift;
  logic [D:0]       dvs_ext;
  logic [D:0]       rem_sub;
  logic             ge;

  assign rem_shift = {rem_q, quo_q[N-1]};
  assign dvs_ext   = {1'b0, dvs_q};
  assign ge        = (rem_shift >= dvs_ext);
  assign rem_sub   = rem_shift - dvs_ext;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so the low D bits hold it.
      rem_d = ge ? rem_sub[D-1:0] : rem_shift[D-1:0];
      quo_d = {quo_q[N-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(N - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/uart_baud_divisor_search.sv
// Baud divisor search. For each requested baud rate the block tries every
// oversampling value from OSR_MIN to OSR_MAX, derives divisor =
// clock / (baud * (osr + 1)) and achieved = clock / (divisor * (osr + 1)), and
// returns the candidate with the smallest absolute error, the smaller
// oversampling value winning a tie. Candidates whose divisor is zero or does
// not fit in DIVISOR_BITS are skipped; if none remains, found is low and all
// other fields are zero. Both divisions of a candidate run on one shared
// restoring divider. The request side is not ready while a search runs.
// The user must write the clock frequency through cfg_we_i / cfg_wdata_i
// only while no search is running; the block itself does not enforce this.
module uart_baud_divisor_search
  import ubds_pkg::*;
#(
  parameter int unsigned OSR_MIN      = 4,
  parameter int unsigned OSR_MAX      = 32,
  parameter int unsigned DIVISOR_BITS = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CLOCK_W-1:0]  cfg_wdata_i,
  ubds_req_if.sink            req_i,
  ubds_rsp_if.source          rsp_o
);

  localparam int unsigned OSR_W = $clog2(OSR_MAX + 2);
  localparam int unsigned PROD_W = BAUD_W + OSR_W;

  ubds_state_e state_q, state_d;

  logic [CLOCK_W-1:0]      clock_q;
  logic [BAUD_W-1:0]       target_q;
  logic [OSR_W-1:0]        osr_q, osr_d;
  logic [DIVISOR_BITS-1:0] div_q;
  logic [RATE_W-1:0]       ach_q;
  logic [RATE_W-1:0]       err_q;
  logic                    hit_q;
  logic [OSR_W-1:0]        best_osr_q;
  logic [DIVISOR_BITS-1:0] best_div_q;
  logic [RATE_W-1:0]       best_ach_q;
  logic [RATE_W-1:0]       best_err_q;

  logic                    rsp_valid_q;
  logic                    rsp_found_q;
  logic [OSR_FIELD_W-1:0]  rsp_osr_q;
  logic [DIV_FIELD_W-1:0]  rsp_div_q;
  logic [RATE_W-1:0]       rsp_ach_q;
  logic [RATE_W-1:0]       rsp_err_q;

  logic                    req_hs;
  logic                    div_start;
  logic                    div_done;
  logic [CLOCK_W-1:0]      quotient;
  logic                    quo_usable;
  logic [BAUD_W-1:0]       mul_a;
  logic [OSR_W-1:0]        osr_plus;
  logic [PROD_W-1:0]       product;
  logic [RATE_W-1:0]       target_ext;
  logic                    last_osr;
  logic                    rsp_free;
  logic                    load_rsp;
  logic                    take_best;

  assign req_hs     = req_i.valid && req_i.ready;
  assign osr_plus   = osr_q + 1'b1;
  assign last_osr   = (osr_q == OSR_W'(OSR_MAX));
  assign target_ext = RATE_W'(target_q);
  assign rsp_free   = !rsp_valid_q || rsp_o.ready;

  // One multiplier serves both divisor products; the divider registers it.
  assign mul_a   = (state_q == S_MUL_A) ? BAUD_W'(div_q) : target_q;
  assign product = PROD_W'(mul_a) * PROD_W'(osr_plus);

  // A zero product makes the divider return all ones, which is out of range.
  assign quo_usable = (quotient != '0) &&
                      (quotient[CLOCK_W-1:DIVISOR_BITS] == '0);

  assign take_best = !hit_q || (err_q < best_err_q);

  ubds_divider #(
    .N (CLOCK_W),
    .D (PROD_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (clock_q),
    .divisor_i  (product),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d = state_q;
    osr_d   = osr_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_hs) begin
          state_d = S_MUL_M;
          osr_d   = OSR_W'(OSR_MIN);
        end
      end
      S_MUL_M: state_d = S_DIV_M;
      S_DIV_M: begin
        if (div_done) begin
          state_d = quo_usable ? S_MUL_A : S_NEXT;
        end
      end
      S_MUL_A: state_d = S_DIV_A;
      S_DIV_A: begin
        if (div_done) begin
          state_d = S_ERR;
        end
      end
      S_ERR:  state_d = S_BEST;
      S_BEST: state_d = S_NEXT;
      S_NEXT: begin
        if (!last_osr) begin
          state_d = S_MUL_M;
          osr_d   = osr_plus;
        end else if (rsp_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    div_start   = 1'b0;
    load_rsp    = 1'b0;
    unique case (state_q)
      S_IDLE:  req_i.ready = 1'b1;
      S_MUL_M: div_start = 1'b1;
      S_MUL_A: div_start = 1'b1;
      S_NEXT:  load_rsp = last_osr && rsp_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clock_q     <= CLOCK_RESET;
      rsp_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      osr_q       <= '0;
    end else begin
      state_q <= state_d;
      osr_q   <= osr_d;
      if (cfg_we_i) begin
        clock_q <= cfg_wdata_i;
      end
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (req_hs) begin
        hit_q <= 1'b0;
      end else if (state_q == S_BEST) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_hs) begin
      target_q   <= req_i.target_baud;
      best_osr_q <= '0;
      best_div_q <= '0;
      best_ach_q <= '0;
      best_err_q <= '0;
    end
    if (state_q == S_DIV_M && div_done) begin
      div_q <= quotient[DIVISOR_BITS-1:0];
    end
    if (state_q == S_DIV_A && div_done) begin
      ach_q <= RATE_W'(quotient);
    end
    if (state_q == S_ERR) begin
      err_q <= (target_ext >= ach_q) ? (target_ext - ach_q) : (ach_q - target_ext);
    end
    // A later candidate replaces the best one only on a strictly smaller error.
    if (state_q == S_BEST && take_best) begin
      best_osr_q <= osr_q;
      best_div_q <= div_q;
      best_ach_q <= ach_q;
      best_err_q <= err_q;
    end
    if (load_rsp) begin
      rsp_found_q <= hit_q;
      rsp_osr_q   <= OSR_FIELD_W'(best_osr_q);
      rsp_div_q   <= DIV_FIELD_W'(best_div_q);
      rsp_ach_q   <= best_ach_q;
      rsp_err_q   <= best_err_q;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.found         = rsp_found_q;
  assign rsp_o.best_osr      = rsp_osr_q;
  assign rsp_o.best_divisor  = rsp_div_q;
  assign rsp_o.achieved_baud = rsp_ach_q;
  assign rsp_o.error_hz      = rsp_err_q;

endmodule
